@@ design/ecma_pkg.sv @@
`timescale 1ns / 1ps
package ecma_pkg;

    localparam int LIMB_COUNT = 4;
    localparam int LIMB_W     = 64;
    localparam int WORD_W     = LIMB_COUNT * LIMB_W;
    localparam int LIDX_W     = $clog2(LIMB_COUNT);
    localparam int STORE_AW   = 2 + LIDX_W;
    localparam int STEP_W     = $clog2(2 * WORD_W);
    localparam int PC_W       = 5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_GATH,
        S_LOAD,
        S_RUN,
        S_OREAD,
        S_OLOAD,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        OP_RED,
        OP_SUB,
        OP_MUL,
        OP_END
    } t_op;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef enum logic [3:0] {
        SL_X1, SL_Y1, SL_X2, SL_Y2,
        SL_H,  SL_R,  SL_H2, SL_H3,
        SL_U,  SL_T,  SL_X3, SL_Y3
    } t_slot;

    localparam logic [1:0] SEL_X1 = 2'd0;
    localparam logic [1:0] SEL_Y1 = 2'd1;
    localparam logic [1:0] SEL_X2 = 2'd2;
    localparam logic [1:0] SEL_Y2 = 2'd3;

    localparam logic [1:0] CO_X3 = 2'd0;
    localparam logic [1:0] CO_Y3 = 2'd1;
    localparam logic [1:0] CO_Z3 = 2'd2;

    typedef struct packed {
        t_op        op;
        t_slot      src_a;
        t_slot      src_b;
        t_slot      dst;
        logic [1:0] grp;
    } t_uop;

    function automatic t_uop ecma_prog(input logic [PC_W-1:0] pc);
        t_uop u;
        u = '{op: OP_END, src_a: SL_X1, src_b: SL_X1, dst: SL_X1, grp: SEL_X1};
        case (pc)
            5'd0:  u = '{OP_RED, SL_X1, SL_X1, SL_X1, SEL_X1};
            5'd1:  u = '{OP_RED, SL_X1, SL_X1, SL_Y1, SEL_Y1};
            5'd2:  u = '{OP_RED, SL_X1, SL_X1, SL_X2, SEL_X2};
            5'd3:  u = '{OP_RED, SL_X1, SL_X1, SL_Y2, SEL_Y2};
            5'd4:  u = '{OP_SUB, SL_X2, SL_X1, SL_H,  SEL_X1};
            5'd5:  u = '{OP_SUB, SL_Y2, SL_Y1, SL_R,  SEL_X1};
            5'd6:  u = '{OP_MUL, SL_H,  SL_H,  SL_H2, SEL_X1};
            5'd7:  u = '{OP_MUL, SL_H2, SL_H,  SL_H3, SEL_X1};
            5'd8:  u = '{OP_MUL, SL_X1, SL_H2, SL_U,  SEL_X1};
            5'd9:  u = '{OP_MUL, SL_R,  SL_R,  SL_T,  SEL_X1};
            5'd10: u = '{OP_SUB, SL_T,  SL_H3, SL_T,  SEL_X1};
            5'd11: u = '{OP_SUB, SL_T,  SL_U,  SL_T,  SEL_X1};
            5'd12: u = '{OP_SUB, SL_T,  SL_U,  SL_X3, SEL_X1};
            5'd13: u = '{OP_SUB, SL_U,  SL_X3, SL_T,  SEL_X1};
            5'd14: u = '{OP_MUL, SL_R,  SL_T,  SL_T,  SEL_X1};
            5'd15: u = '{OP_MUL, SL_Y1, SL_H3, SL_U,  SEL_X1};
            5'd16: u = '{OP_SUB, SL_T,  SL_U,  SL_Y3, SEL_X1};
            default: u = '{OP_END, SL_X1, SL_X1, SL_X1, SEL_X1};
        endcase
        return u;
    endfunction

endpackage

@@ design/ec_mixed_point_add.sv @@
`timescale 1ns / 1ps
// channel  | valid   | stall   | payload
// input    | i_valid | o_stall | i_coord_select i_limb_index i_limb_value i_compute
// output   | o_valid | i_stall | o_coord_out o_out_limb_index o_result_limb o_last
// config   | psel/penable/pwrite | pready=1 | paddr pwdata prdata
// a compute transaction's time to the first result is set by the bit-serial modular
// multiply: the shared modular adder doubles and then adds for each operand bit, per
// multiply or operand reduction (ten of them).
// the 12 result limbs leave as three bursts of four, one per cycle when the output is
// not stalled, with states S_OREAD and S_OLOAD between coordinates to fetch the next one.
// synchronous active-low reset returns the sequencer to idle and restores the prime.
// o_stall is high until the last result limb is loaded into the output register.
module ec_mixed_point_add import ecma_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_coord_select,
    input  logic [1:0]          i_limb_index,
    input  logic [LIMB_W-1:0]   i_limb_value,
    input  logic                i_compute,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [1:0]          o_coord_out,
    output logic [1:0]          o_out_limb_index,
    output logic [LIMB_W-1:0]   o_result_limb,
    output logic                o_last,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);

    t_state                 r_state, n_state;
    logic [PC_W-1:0]        r_pc;
    logic [STEP_W-1:0]      r_cnt;
    logic [WORD_W-1:0]      r_acc, r_a, r_b, r_ow;
    logic [WORD_W-1:0]      r_rda, r_rdb;
    logic [LIMB_W-1:0]      r_srd;
    logic [1:0]             r_oc;
    logic [LIDX_W-1:0]      r_ol;
    logic [LIMB_W-1:0]      r_prime [LIMB_COUNT];
    logic                   r_valid, r_last;
    logic [1:0]             r_coord, r_lidx;
    logic [LIMB_W-1:0]      r_limb;

    logic [WORD_W-1:0]      wmem [16];
    logic [LIMB_W-1:0]      smem [4*LIMB_COUNT];

    t_uop                   uop;
    logic                   in_acc, out_free, step_last, gath_done, p_zero;
    logic [WORD_W-1:0]      prime_w, alu_x, alu_y, alu_r;
    t_alu_op                alu_op;
    t_slot                  rd_a, rd_b;
    logic                   w_en;
    t_slot                  w_addr;
    logic [WORD_W-1:0]      w_data;
    logic [STORE_AW-1:0]    s_raddr;

    assign uop       = ecma_prog(r_pc);
    assign in_acc    = i_valid && !o_stall;
    assign out_free  = !r_valid || !i_stall;
    assign step_last = (r_cnt == STEP_W'(2 * WORD_W - 1));
    assign gath_done = (r_cnt == STEP_W'(LIMB_COUNT));
    assign o_stall   = (r_state != S_IDLE);

    always_comb begin
        for (int k = 0; k < LIMB_COUNT; k++) begin
            prime_w[k*LIMB_W +: LIMB_W] = r_prime[k];
        end
    end
    assign p_zero = (prime_w == '0);

    ecma_modalu u_alu (
        .i_op (alu_op),
        .i_x  (alu_x),
        .i_y  (alu_y),
        .i_p  (prime_w),
        .o_r  (alu_r)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_acc && i_compute) n_state = S_FETCH;
            S_FETCH: begin
                case (uop.op)
                    OP_RED:  n_state = S_GATH;
                    OP_END:  n_state = S_OREAD;
                    default: n_state = S_LOAD;
                endcase
            end
            S_GATH:  if (gath_done) n_state = S_RUN;
            S_LOAD:  n_state = (uop.op == OP_MUL) ? S_RUN : S_FETCH;
            S_RUN:   if (step_last) n_state = S_FETCH;
            S_OREAD: n_state = S_OLOAD;
            S_OLOAD: n_state = S_OUT;
            S_OUT: begin
                if (out_free && r_ol == LIDX_W'(LIMB_COUNT - 1))
                    n_state = (r_oc == CO_Z3) ? S_IDLE : S_OREAD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        alu_op  = ALU_ADD;
        alu_x   = r_acc;
        alu_y   = r_acc;
        rd_a    = uop.src_a;
        rd_b    = uop.src_b;
        w_en    = 1'b0;
        w_addr  = uop.dst;
        w_data  = alu_r;
        s_raddr = {uop.grp, r_cnt[LIDX_W-1:0]};
        case (r_state)
            S_LOAD: begin
                alu_op = ALU_SUB;
                alu_x  = r_rda;
                alu_y  = r_rdb;
                w_en   = (uop.op == OP_SUB);
            end
            S_RUN: begin
                if (r_cnt[0]) alu_y = r_b[WORD_W-1] ? r_a : '0;
                w_en = step_last;
            end
            S_OREAD: begin
                case (r_oc)
                    CO_X3:   rd_a = SL_X3;
                    CO_Y3:   rd_a = SL_Y3;
                    default: rd_a = SL_H;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rda <= wmem[rd_a];
        r_rdb <= wmem[rd_b];
        if (w_en) wmem[w_addr] <= w_data;
    end

    always_ff @(posedge i_clk) begin
        r_srd <= smem[s_raddr];
        if (in_acc && ({1'b0, i_limb_index} < 3'(LIMB_COUNT)))
            smem[{i_coord_select, i_limb_index[LIDX_W-1:0]}] <= i_limb_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
            r_cnt   <= '0;
            r_oc    <= CO_X3;
            r_ol    <= '0;
            r_valid <= 1'b0;
            r_prime[0] <= 64'hFFFF_FFFE_FFFF_FC2F;
            for (int k = 1; k < LIMB_COUNT; k++) r_prime[k] <= '1;
        end else begin
            r_state <= n_state;
            if (psel && penable && pwrite && pready && ({1'b0, paddr[4:3]} < 3'(LIMB_COUNT)))
                r_prime[paddr[4:3]] <= pwdata;
            if (out_free) r_valid <= (r_state == S_OUT);
            case (r_state)
                S_IDLE: r_pc <= '0;
                S_FETCH: begin
                    r_cnt <= '0;
                    r_oc  <= CO_X3;
                end
                S_GATH: begin
                    r_cnt <= gath_done ? '0 : r_cnt + 1'b1;
                    if (r_cnt != '0) r_b <= {r_srd, r_b[WORD_W-1:LIMB_W]};
                    r_a   <= WORD_W'(1);
                    r_acc <= '0;
                end
                S_LOAD: begin
                    r_a   <= r_rda;
                    r_b   <= r_rdb;
                    r_acc <= '0;
                    r_cnt <= '0;
                    if (uop.op != OP_MUL) r_pc <= r_pc + 1'b1;
                end
                S_RUN: begin
                    r_acc <= alu_r;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt[0]) r_b <= {r_b[WORD_W-2:0], 1'b0};
                    if (step_last) r_pc <= r_pc + 1'b1;
                end
                S_OLOAD: begin
                    r_ow <= p_zero ? '0 : r_rda;
                    r_ol <= '0;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_coord <= r_oc;
                        r_lidx  <= 2'(r_ol);
                        r_limb  <= r_ow[r_ol*LIMB_W +: LIMB_W];
                        r_last  <= (r_oc == CO_Z3) && (r_ol == LIDX_W'(LIMB_COUNT - 1));
                        r_ol    <= r_ol + 1'b1;
                        if (r_ol == LIDX_W'(LIMB_COUNT - 1)) r_oc <= r_oc + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid          = r_valid;
    assign o_coord_out      = r_coord;
    assign o_out_limb_index = r_lidx;
    assign o_result_limb    = r_limb;
    assign o_last           = r_last;

    assign pready = 1'b1;
    always_comb begin
        prdata = '0;
        if ({1'b0, paddr[4:3]} < 3'(LIMB_COUNT)) prdata = r_prime[paddr[4:3]];
    end

    a_last_z3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_coord_out == CO_Z3 && o_out_limb_index == 2'd3))
        else $error("last flag off the final z3 limb");

    a_run_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (uop.op == OP_MUL || uop.op == OP_RED))
        else $error("bit-serial loop running a non-multiply step");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_compute) |=> o_stall)
        else $error("input not stalled after compute transaction");

endmodule

@@ design/ecma_modalu.sv @@
`timescale 1ns / 1ps
module ecma_modalu import ecma_pkg::*; (
    input  t_alu_op             i_op,
    input  logic [WORD_W-1:0]   i_x,
    input  logic [WORD_W-1:0]   i_y,
    input  logic [WORD_W-1:0]   i_p,
    output logic [WORD_W-1:0]   o_r
);

    logic [WORD_W:0]   sum;
    logic [WORD_W+1:0] red;
    logic [WORD_W:0]   dif;
    logic [WORD_W-1:0] fix;

    // operands below p: one correction step suffices
    always_comb begin
        sum = {1'b0, i_x} + {1'b0, i_y};
        red = {1'b0, sum} - {2'b00, i_p};
        dif = {1'b0, i_x} - {1'b0, i_y};
        fix = dif[WORD_W-1:0] + i_p;
        case (i_op)
            ALU_ADD: o_r = red[WORD_W+1] ? sum[WORD_W-1:0] : red[WORD_W-1:0];
            ALU_SUB: o_r = dif[WORD_W] ? fix : dif[WORD_W-1:0];
            default: o_r = sum[WORD_W-1:0];
        endcase
    end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
    import ecma_pkg::*;

    localparam int CYCLE_LIMIT = 10000000;

    typedef struct {
        logic [1:0]        coord;
        logic [1:0]        lidx;
        logic [LIMB_W-1:0] limb;
        logic              last;
    } t_limb_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [1:0]        i_coord_select;
    logic [1:0]        i_limb_index;
    logic [LIMB_W-1:0] i_limb_value;
    logic              i_compute;
    logic              o_valid;
    logic              i_stall;
    logic [1:0]        o_coord_out;
    logic [1:0]        o_out_limb_index;
    logic [LIMB_W-1:0] o_result_limb;
    logic              o_last;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [4:0]        paddr;
    logic [63:0]       pwdata;
    logic [63:0]       prdata;
    logic              pready;

    ec_mixed_point_add u_top (.*);

    // predictor state
    logic [63:0]  operand_mem [16];
    logic [63:0]  prime_limbs [4];
    t_limb_result point_q [$];

    int  mismatches;
    int  results_seen;
    int  items_sent;
    int  computes_sent;
    int  cycle_count;
    bit  idle_on;
    int  hold_req;
    int  hold_left;
    int  rx_burst;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, point_q.size());
            $display("ec_mixed_point_add: mismatch");
            $finish;
        end
    end

    function automatic logic [255:0] sub_mod(logic [255:0] a, logic [255:0] b,
                                             logic [255:0] p);
        return (a >= b) ? a - b : a - b + p;
    endfunction

    function automatic logic [255:0] mul_mod(logic [255:0] a, logic [255:0] b,
                                             logic [255:0] p);
        logic [511:0] prod;
        prod = {256'b0, a} * {256'b0, b};
        return 256'(prod % {256'b0, p});
    endfunction

    function automatic logic [255:0] operand_vec(int sel);
        return {operand_mem[sel*4+3], operand_mem[sel*4+2],
                operand_mem[sel*4+1], operand_mem[sel*4]};
    endfunction

    task automatic predict_point();
        logic [255:0] p, x1, y1, x2, y2, h, r, h2, h3, u, t;
        logic [255:0] coords [3];
        logic [1:0]   codes [3];
        t_limb_result e;
        p = {prime_limbs[3], prime_limbs[2], prime_limbs[1], prime_limbs[0]};
        codes[0] = CO_X3;
        codes[1] = CO_Y3;
        codes[2] = CO_Z3;
        if (p == 0) begin
            coords[0] = '0;
            coords[1] = '0;
            coords[2] = '0;
        end else begin
            x1 = operand_vec(SEL_X1) % p;
            y1 = operand_vec(SEL_Y1) % p;
            x2 = operand_vec(SEL_X2) % p;
            y2 = operand_vec(SEL_Y2) % p;
            h  = sub_mod(x2, x1, p);
            r  = sub_mod(y2, y1, p);
            h2 = mul_mod(h, h, p);
            h3 = mul_mod(h2, h, p);
            u  = mul_mod(x1, h2, p);
            t  = mul_mod(r, r, p);
            t  = sub_mod(t, h3, p);
            t  = sub_mod(t, u, p);
            coords[0] = sub_mod(t, u, p);
            t  = sub_mod(u, coords[0], p);
            t  = mul_mod(r, t, p);
            u  = mul_mod(y1, h3, p);
            coords[1] = sub_mod(t, u, p);
            coords[2] = h;
        end
        for (int c = 0; c < 3; c++) begin
            for (int l = 0; l < LIMB_COUNT; l++) begin
                e.coord = codes[c];
                e.lidx  = 2'(l);
                e.limb  = coords[c][l*64 +: 64];
                e.last  = (c == 2 && l == LIMB_COUNT - 1);
                point_q.push_back(e);
            end
        end
    endtask

    function automatic logic [63:0] rand_limb();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 64'($urandom_range(0, 255));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_limb(logic [1:0] sel, logic [1:0] idx, logic [63:0] val,
                             logic cmp);
        @(negedge i_clk);
        i_valid        <= 1'b1;
        i_coord_select <= sel;
        i_limb_index   <= idx;
        i_limb_value   <= val;
        i_compute      <= cmp;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
        operand_mem[sel*4 + idx] = val;
        if (cmp) begin
            computes_sent++;
            predict_point();
        end
        if (idle_on && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge i_clk);
        end
    endtask

    // all 16 limbs in a random order, compute on the final one
    task automatic send_point_load();
        int order [16];
        int j, tmp;
        for (int k = 0; k < 16; k++) order[k] = k;
        for (int k = 15; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        for (int k = 0; k < 16; k++)
            send_limb(2'(order[k] / 4), 2'(order[k] % 4), rand_limb(), k == 15);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (point_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_prime(int idx, logic [63:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(idx * 8);
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        prime_limbs[idx] = val;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_prime(logic [255:0] p);
        wait_drained();
        for (int k = 0; k < 4; k++) write_prime(k, p[k*64 +: 64]);
    endtask

    // receiver: random stall bursts, plus long holds on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_req > 0) begin
            hold_left = hold_req - 1;
            hold_req  = 0;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (!idle_on) begin
            i_stall <= 1'b0;
        end else if (rx_burst > 0) begin
            rx_burst--;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            rx_burst = $urandom_range(0, 3);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_limb_result e;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (point_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result limb %h coord %0d idx %0d",
                             o_result_limb, o_coord_out, o_out_limb_index);
            end else begin
                e = point_q.pop_front();
                if (o_coord_out !== e.coord || o_out_limb_index !== e.lidx ||
                    o_result_limb !== e.limb || o_last !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: exp %0d/%0d/%h/%b got %0d/%0d/%h/%b",
                                 results_seen, e.coord, e.lidx, e.limb, e.last,
                                 o_coord_out, o_out_limb_index, o_result_limb,
                                 o_last);
                end
            end
        end
    end

    task automatic test_directed();
        send_point_load();
        // equal x gives Z3 = 0
        for (int k = 0; k < 4; k++)
            send_limb(SEL_X2, 2'(k), operand_mem[SEL_X1*4 + k], k == 3);
        // single-limb changes, including all-ones limbs that can put an operand above p
        send_limb(SEL_Y2, 2'd3, '1, 1'b1);
        send_limb(SEL_X1, 2'd0, '1, 1'b1);
        send_limb(SEL_Y1, 2'd2, 64'h0, 1'b1);
        send_limb(SEL_X2, 2'd1, 64'h8000_0000_0000_0001, 1'b1);
    endtask

    task automatic test_prime_settings();
        set_prime(256'd13);
        send_limb(SEL_X2, 2'd0, 64'd5, 1'b1);
        set_prime(256'd1);
        send_limb(SEL_Y2, 2'd0, 64'd7, 1'b1);
        set_prime('0);
        send_limb(SEL_X1, 2'd3, {$urandom, $urandom}, 1'b1);
        set_prime('1);
        send_point_load();
        set_prime({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom});
        send_point_load();
        set_prime(256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_FFFFFC2F);
    endtask

    task automatic test_random(int n_items);
        int stop;
        stop = items_sent + n_items;
        while (items_sent < stop) begin
            if ($urandom_range(0, 3) != 0)
                send_point_load();
            else
                send_limb(2'($urandom), 2'($urandom), rand_limb(),
                          $urandom_range(0, 5) == 0);
        end
    endtask

    task automatic test_backpressure();
        send_limb(SEL_Y1, 2'd1, rand_limb(), 1'b1);
        // long receiver hold once the first result limb shows up
        @(posedge i_clk iff o_valid);
        hold_req = 400;
        send_limb(SEL_X2, 2'd2, rand_limb(), 1'b1);
        send_limb(SEL_Y2, 2'd0, rand_limb(), 1'b0);
        // sender pauses until everything is back
        wait_drained();
        send_limb(SEL_X1, 2'd1, rand_limb(), 1'b1);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_coord_select = '0;
        i_limb_index = '0;
        i_limb_value = '0;
        i_compute = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        computes_sent = 0;
        cycle_count = 0;
        hold_req = 0;
        hold_left = 0;
        rx_burst = 0;
        idle_on = 1'b1;
        prime_limbs[0] = 64'hFFFFFFFE_FFFFFC2F;
        prime_limbs[1] = '1;
        prime_limbs[2] = '1;
        prime_limbs[3] = '1;
        for (int k = 0; k < 16; k++) operand_mem[k] = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_prime_settings();
        test_backpressure();
        test_random(150);
        wait_drained();
        idle_on = 1'b0;
        test_random(60);

        wait_drained();
        repeat (50) @(posedge i_clk);
        $display("sent %0d limb transactions, %0d point computations, %0d result limbs",
                 items_sent, computes_sent, results_seen);
        $display("primes: default, 13, 1, zero, all ones, random; %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("ec_mixed_point_add: match");
        else
            $display("ec_mixed_point_add: mismatch");
        $finish;
    end

endmodule
